/* src/sem_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and the result tag type of the Sobel block.
package sem_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // frame size limits
  localparam int MIN_SIZE       = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // arithmetic widths: kernel half-sums, gradients, sum of squares, root
  localparam int SUM_W = PIX_W + 2;
  localparam int G_W   = SUM_W + 1;
  localparam int SQ_W  = 2 * G_W - 1;
  localparam int RT_W  = (SQ_W + 1) / 2;

  // register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET   = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET  = 11'd480;
  localparam logic [PIX_W-1:0] CEILING_RESET = 8'd255;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_CLAMP_CEILING
  } cfg_reg_t;

  // tag that travels with a result through the arithmetic pipeline
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } res_meta_t;

endpackage

/* src/sem_if.sv */
`timescale 1ns / 1ps
// Stream interfaces for the pixel input and the edge result output.
interface sem_pixel_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface sem_edge_if;
  import sem_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   edge_value;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               frame_last;

  modport source (output valid, edge_value, out_col, out_row, frame_last, input ready);
  modport sink   (input valid, edge_value, out_col, out_row, frame_last, output ready);
endinterface

/* src/sem_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port (read-first).
module sem_ram #(
  parameter int WIDTH = sem_pkg::PIX_W,
  parameter int DEPTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sem_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage, with a tag carried alongside.
module sem_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [sem_pkg::SQ_W-1:0] in_value,
  input  sem_pkg::res_meta_t       in_meta,
  output logic                     out_valid,
  output logic [sem_pkg::RT_W-1:0] out_root,
  output sem_pkg::res_meta_t       out_meta
);
  import sem_pkg::*;

  localparam int REM_W = SQ_W + 1;

  // per-stage registers: remainder v - root^2, partial root, valid, tag
  logic [REM_W-1:0] rem_q   [RT_W];
  logic [RT_W-1:0]  root_q  [RT_W];
  logic             valid_q [RT_W];
  res_meta_t        meta_q  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    localparam int B = RT_W - 1 - k;

    logic [REM_W-1:0] r_in;
    logic [REM_W-1:0] trial;
    logic [RT_W-1:0]  q_in;
    logic             v_in;
    res_meta_t        m_in;

    if (k == 0) begin : g_first
      assign r_in = REM_W'(in_value);
      assign q_in = '0;
      assign v_in = in_valid;
      assign m_in = in_meta;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign v_in = valid_q[k-1];
      assign m_in = meta_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (REM_W'(q_in) << (B + 1)) + (REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= v_in;
      end
      if (adv) begin
        meta_q[k] <= m_in;
        if (r_in >= trial) begin
          rem_q[k]  <= r_in - trial;
          root_q[k] <= q_in | (RT_W'(1) << B);
        end else begin
          rem_q[k]  <= r_in;
          root_q[k] <= q_in;
        end
      end
    end
  end

  assign out_valid = valid_q[RT_W-1];
  assign out_root  = root_q[RT_W-1];
  assign out_meta  = meta_q[RT_W-1];

endmodule

/* src/sobel_edge_magnitude.sv */
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude over raster-order grayscale pixels.
// Throughput: one pixel word per clock; the pipeline stops only while the output
// register holds an untaken word and a finished result waits behind it.
// Pipeline from pixel accept to result: line buffer read, window, gradients, squares,
// sum, 11 root stages, clamp and output register.
// Reset clears counters, pipeline valids and registers to defaults; line RAMs stay uncleared.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  sem_pixel_if.sink                     pixels,
  sem_edge_if.source                    edges
);
  import sem_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CWP = CW + 1;
  localparam int RWP = RW + 1;
  localparam int LWW = (CWP > CFG_W) ? CWP : CFG_W;
  localparam int LHW = (RWP > CFG_W) ? RWP : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [PIX_W-1:0] clamp_ceiling;
  cfg_reg_t         cfg_sel;

  assign cfg_sel = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      clamp_ceiling <= CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_CLAMP_CEILING: clamp_ceiling <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, saturated to the supported range
  logic [LWW-1:0] w_ext;
  logic [LHW-1:0] h_ext;
  logic [CW:0]    w_eff;
  logic [RW:0]    h_eff;

  always_comb begin
    w_ext = LWW'(image_width);
    if (w_ext < LWW'(MIN_SIZE)) begin
      w_ext = LWW'(MIN_SIZE);
    end else if (w_ext > LWW'(MAX_WIDTH)) begin
      w_ext = LWW'(MAX_WIDTH);
    end
    h_ext = LHW'(image_height);
    if (h_ext < LHW'(MIN_SIZE)) begin
      h_ext = LHW'(MIN_SIZE);
    end else if (h_ext > LHW'(MAX_HEIGHT)) begin
      h_ext = LHW'(MAX_HEIGHT);
    end
    w_eff = CWP'(w_ext);
    h_eff = RWP'(h_ext);
  end

  // handshake: the pipeline moves unless a finished root is blocked by a held output
  logic res_valid;
  logic sq_vo;
  logic adv;
  logic accept;

  assign adv          = !res_valid || edges.ready || !sq_vo;
  assign pixels.ready = adv;
  assign accept       = pixels.valid && adv;

  // raster position of the incoming pixel and of the one after it
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW:0]   c_a;
  logic [RW:0]   r_a;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [CW-1:0] col_nx;
  logic [RW-1:0] row_nx;

  always_comb begin
    c_a = pixels.frame_start ? '0 : {1'b0, column_count};
    r_a = pixels.frame_start ? '0 : {1'b0, row_count};
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = r_a + RWP'(1);
    end
    if (r_a >= h_eff) begin
      r_a = '0;
    end
    cur_col = c_a[CW-1:0];
    cur_row = r_a[RW-1:0];

    col_inc = {1'b0, cur_col} + CWP'(1);
    row_inc = {1'b0, cur_row} + RWP'(1);
    if (col_inc >= w_eff) begin
      col_nx = '0;
      row_nx = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nx = col_inc[CW-1:0];
      row_nx = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= col_nx;
      row_count    <= row_nx;
    end
  end

  // result tag of the incoming pixel
  logic      cur_res;
  res_meta_t cur_meta;

  always_comb begin
    cur_res       = (cur_col >= CW'(2)) && (cur_row >= RW'(2));
    cur_meta.col  = COORD_W'(cur_col - CW'(1));
    cur_meta.row  = COORD_W'(cur_row - RW'(1));
    cur_meta.last = ({1'b0, cur_col} == w_eff - CWP'(1)) &&
                    ({1'b0, cur_row} == h_eff - RWP'(1));
  end

  // stage 1: line-buffer read data arrives, write-back of the same column
  logic             p1_valid;
  logic [CW-1:0]    p1_col;
  logic [PIX_W-1:0] p1_pix;
  logic             p1_hz;
  logic [PIX_W-1:0] p1_fwd_older;
  logic [PIX_W-1:0] p1_fwd_newer;
  logic             p1_res;
  res_meta_t        p1_meta;
  logic [PIX_W-1:0] older_rd;
  logic [PIX_W-1:0] newer_rd;
  logic [PIX_W-1:0] older_eff;
  logic [PIX_W-1:0] newer_eff;
  logic             wr_en;

  // the previous word wrote this column in the cycle of our read: take its data
  assign older_eff = p1_hz ? p1_fwd_older : older_rd;
  assign newer_eff = p1_hz ? p1_fwd_newer : newer_rd;
  assign wr_en     = adv && p1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= accept;
    end
    if (accept) begin
      p1_col       <= cur_col;
      p1_pix       <= pixels.pixel_value;
      p1_hz        <= p1_valid && (p1_col == cur_col);
      p1_fwd_older <= newer_eff;
      p1_fwd_newer <= p1_pix;
      p1_res       <= cur_res;
      p1_meta      <= cur_meta;
    end
  end

  sem_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_older (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p1_col),
    .wdata (newer_eff),
    .re    (accept),
    .raddr (cur_col),
    .rdata (older_rd)
  );

  sem_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_newer (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p1_col),
    .wdata (p1_pix),
    .re    (accept),
    .raddr (cur_col),
    .rdata (newer_rd)
  );

  // stage 2: 3x3 window, index r*3+c with c = 2 the newest column
  logic [PIX_W-1:0] wnd [9];
  logic             p2_valid;
  res_meta_t        p2_meta;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        wnd[r*3]   <= wnd[r*3+1];
        wnd[r*3+1] <= wnd[r*3+2];
      end
      wnd[2] <= older_eff;
      wnd[5] <= newer_eff;
      wnd[8] <= p1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid && p1_res;
    end
    if (adv) begin
      p2_meta <= p1_meta;
    end
  end

  // stage 3: Sobel gradients
  logic [SUM_W-1:0]    x_pos;
  logic [SUM_W-1:0]    x_neg;
  logic [SUM_W-1:0]    y_pos;
  logic [SUM_W-1:0]    y_neg;
  logic signed [G_W-1:0] gx_c;
  logic signed [G_W-1:0] gy_c;
  logic signed [G_W-1:0] p3_gx;
  logic signed [G_W-1:0] p3_gy;
  logic                  p3_valid;
  res_meta_t             p3_meta;

  always_comb begin
    x_pos = SUM_W'(wnd[2]) + {1'b0, wnd[5], 1'b0} + SUM_W'(wnd[8]);
    x_neg = SUM_W'(wnd[0]) + {1'b0, wnd[3], 1'b0} + SUM_W'(wnd[6]);
    y_pos = SUM_W'(wnd[6]) + {1'b0, wnd[7], 1'b0} + SUM_W'(wnd[8]);
    y_neg = SUM_W'(wnd[0]) + {1'b0, wnd[1], 1'b0} + SUM_W'(wnd[2]);
    gx_c  = signed'({1'b0, x_pos}) - signed'({1'b0, x_neg});
    gy_c  = signed'({1'b0, y_pos}) - signed'({1'b0, y_neg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid;
    end
    if (adv) begin
      p3_gx   <= gx_c;
      p3_gy   <= gy_c;
      p3_meta <= p2_meta;
    end
  end

  // stage 4: squares
  logic signed [2*G_W-1:0] gx_sq;
  logic signed [2*G_W-1:0] gy_sq;
  logic [SQ_W-1:0]         p4_sqx;
  logic [SQ_W-1:0]         p4_sqy;
  logic                    p4_valid;
  res_meta_t               p4_meta;

  assign gx_sq = p3_gx * p3_gx;
  assign gy_sq = p3_gy * p3_gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (adv) begin
      p4_valid <= p3_valid;
    end
    if (adv) begin
      p4_sqx  <= SQ_W'(gx_sq);
      p4_sqy  <= SQ_W'(gy_sq);
      p4_meta <= p3_meta;
    end
  end

  // stage 5: sum of squares
  logic [SQ_W-1:0] p5_sum;
  logic            p5_valid;
  res_meta_t       p5_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (adv) begin
      p5_valid <= p4_valid;
    end
    if (adv) begin
      p5_sum  <= p4_sqx + p4_sqy;
      p5_meta <= p4_meta;
    end
  end

  // root stages
  logic [RT_W-1:0] sq_root;
  res_meta_t       sq_meta;

  sem_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p5_valid),
    .in_value  (p5_sum),
    .in_meta   (p5_meta),
    .out_valid (sq_vo),
    .out_root  (sq_root),
    .out_meta  (sq_meta)
  );

  // clamp and output register
  logic [PIX_W-1:0]   res_value;
  logic [COORD_W-1:0] res_col;
  logic [COORD_W-1:0] res_row;
  logic               res_last;
  logic               out_free;

  assign out_free = !res_valid || edges.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= sq_vo;
    end
    if (out_free) begin
      res_value <= (sq_root > RT_W'(clamp_ceiling)) ? clamp_ceiling : sq_root[PIX_W-1:0];
      res_col   <= sq_meta.col;
      res_row   <= sq_meta.row;
      res_last  <= sq_meta.last;
    end
  end

  assign edges.valid      = res_valid;
  assign edges.edge_value = res_value;
  assign edges.out_col    = res_col;
  assign edges.out_row    = res_row;
  assign edges.frame_last = res_last;

  // a finished root moving on always lands in the output register
  a_root_lands: assert property (@(posedge clk) disable iff (rst)
    (sq_vo && adv) |=> res_valid)
    else $error("finished root lost on its way to the output register");

  // a blocked root stays put
  a_root_held: assert property (@(posedge clk) disable iff (rst)
    (sq_vo && !adv) |=> sq_vo)
    else $error("finished root dropped during a stall");

  // an accepted word enters the line-buffer stage
  a_word_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> p1_valid)
    else $error("accepted pixel word missing from the line-buffer stage");

  // a stalled line-buffer stage keeps its column for the pending write-back
  a_wb_column_held: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && !adv) |=> (p1_valid && $stable(p1_col)))
    else $error("line-buffer write-back column changed during a stall");

endmodule

/* sim/sobel_edge_magnitude_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the streaming Sobel edge magnitude block.
module sobel_edge_magnitude_tb;
  import sem_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 40;        // border pixels give no word
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 250;

  // one expected edge word
  typedef struct packed {
    logic [PIX_W-1:0]   edge_value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } edge_word_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  cfg_reg_t           cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  sem_pixel_if pix_bus ();
  sem_edge_if  edge_bus ();

  sobel_edge_magnitude dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_bus),
    .edges     (edge_bus)
  );

  // predictor state: two previous rows, 3x3 neighbourhood, raster position
  logic [PIX_W-1:0] row_above2 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] row_above1 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] nbhd [3][3];            // [row][col], col 2 is the newest
  int unsigned      pos_col;
  int unsigned      pos_row;
  logic [CFG_W-1:0] reg_width;
  logic [CFG_W-1:0] reg_height;
  logic [PIX_W-1:0] reg_ceiling;

  edge_word_t  edge_expect [$];
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned edges_checked;
  int unsigned frames_done;
  int unsigned cycle_count;
  int unsigned random_sent;

  // traffic shaping
  bit          sender_idle_on;
  bit          sink_stall_on;
  int unsigned burst_left;
  int unsigned stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d edge words outstanding",
               cycle_count, edge_expect.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: ready drops for runs of random length when stalling is on
  always @(negedge clk) begin
    if (!sink_stall_on) begin
      edge_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      edge_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      edge_bus.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned top);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > top) return top;
    return v;
  endfunction

  // advance the raster position and queue the edge word this pixel produces, if any
  function automatic void predict_edge(input logic [PIX_W-1:0] pixel, input logic start);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          k;
    int          gx;
    int          gy;
    int          sq;
    int          mag;
    int          trial;
    edge_word_t  word;
    w = eff_size(reg_width, MAX_WIDTH_DEF);
    h = eff_size(reg_height, MAX_HEIGHT_DEF);
    if (start) begin
      pos_col = 0;
      pos_row = 0;
    end
    // size may have shrunk under the current position
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;

    for (k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = row_above2[c];
    nbhd[1][2] = row_above1[c];
    nbhd[2][2] = pixel;
    row_above2[c] = row_above1[c];
    row_above1[c] = pixel;

    if (c >= 2 && r >= 2) begin
      gx = int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2])
         - int'(nbhd[0][0]) - 2 * int'(nbhd[1][0]) - int'(nbhd[2][0]);
      gy = int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2])
         - int'(nbhd[0][0]) - 2 * int'(nbhd[0][1]) - int'(nbhd[0][2]);
      sq = gx * gx + gy * gy;
      // floor root, one bit at a time from the top
      mag = 0;
      for (k = 10; k >= 0; k--) begin
        trial = mag | (1 << k);
        if (trial * trial <= sq) mag = trial;
      end
      if (mag > int'(reg_ceiling)) mag = int'(reg_ceiling);
      word.edge_value = PIX_W'(mag);
      word.col        = COORD_W'(c - 1);
      word.row        = COORD_W'(r - 1);
      word.last       = (c == w - 1) && (r == h - 1);
      edge_expect.insert(edge_expect.size(), word);
    end

    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // compare every edge word taken with the oldest expectation
  always @(posedge clk) begin : check_edges
    edge_word_t want;
    if (!rst && edge_bus.valid === 1'b1 && edge_bus.ready === 1'b1) begin
      if (edge_expect.size() == 0) begin
        $error("unexpected edge word: col %0d row %0d value %0d",
               edge_bus.out_col, edge_bus.out_row, edge_bus.edge_value);
        error_count++;
      end else begin
        want = edge_expect.pop_front();
        if (edge_bus.edge_value !== want.edge_value) begin
          $error("edge_value mismatch at col %0d row %0d: expected %0d, got %0d",
                 want.col, want.row, want.edge_value, edge_bus.edge_value);
          error_count++;
        end
        if (edge_bus.out_col !== want.col) begin
          $error("out_col mismatch: expected %0d, got %0d", want.col, edge_bus.out_col);
          error_count++;
        end
        if (edge_bus.out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, edge_bus.out_row);
          error_count++;
        end
        if (edge_bus.frame_last !== want.last) begin
          $error("frame_last mismatch at col %0d row %0d: expected %0d, got %0d",
                 want.col, want.row, want.last, edge_bus.frame_last);
          error_count++;
        end
        edges_checked++;
        if (want.last) frames_done++;
      end
    end
  end

  // register write, only while the block is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   reg_width   = value;
      REG_IMAGE_HEIGHT:  reg_height  = value;
      REG_CLAMP_CEILING: reg_ceiling = value[PIX_W-1:0];
      default: ;
    endcase
  endtask

  // offer one pixel word, with random gaps between bursts when idling is on
  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic start);
    int unsigned gap;
    gap = 0;
    if (sender_idle_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap        = $urandom_range(1, 6);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= value;
    pix_bus.frame_start <= start;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    predict_edge(value, start);
    pixels_sent++;
  endtask

  // stop offering, wait for every edge word, then let border pixels clear the pipe
  task automatic drain();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (edge_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned mode,
                                                  input int unsigned base);
    case (mode)
      0: return PIX_W'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return PIX_W'(base + $urandom_range(0, 7));      // smooth area, small gradients
      default:
        return $urandom_range(0, 1) ? PIX_W'($urandom_range(240, 255))
                                    : PIX_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_random(input int unsigned count, input bit first_start);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(pick_pixel(0, 0), first_start && i == 0);
  endtask

  // one default 640 wide row with no frame start, relying on counters cleared by reset;
  // the row must close at 640, then a 4x4 size finishes the frame from row 1
  task automatic test_reset_defaults();
    sender_idle_on = 1'b0;
    sink_stall_on  = 1'b0;
    send_random(640, 1'b0);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd4);
    write_reg(REG_IMAGE_HEIGHT, 11'd4);
    send_random(3 * 4, 1'b0);
    drain();
  endtask

  // hand-made 5x5 frame with full-scale steps, flat areas and mid values
  task automatic send_step_pattern();
    logic [PIX_W-1:0] pattern [25];
    int unsigned      i;
    pattern = '{8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
                8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
                8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
                8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
                8'd128, 8'd1,   8'd254, 8'd127, 8'd0};
    for (i = 0; i < 25; i++) send_pixel(pattern[i], i == 0);
  endtask

  task automatic test_step_edges();
    write_reg(REG_IMAGE_WIDTH, 11'd5);
    write_reg(REG_IMAGE_HEIGHT, 11'd5);
    sender_idle_on = 1'b1;
    sink_stall_on  = 1'b1;
    send_step_pattern();
    drain();
  endtask

  // same frame with the ceiling at zero and at a middle value
  task automatic test_clamp_ceiling();
    write_reg(REG_CLAMP_CEILING, 11'd0);
    send_step_pattern();
    drain();
    write_reg(REG_CLAMP_CEILING, 11'd100);
    send_step_pattern();
    drain();
    write_reg(REG_CLAMP_CEILING, 11'd255);
  endtask

  // sizes below range saturate to the minimum; a height above range saturates too
  task automatic test_size_limits();
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    send_random(9, 1'b1);
    send_random(9, 1'b0);                   // position wraps after the last pixel
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    send_random(3 * 5, 1'b1);
    drain();
  endtask

  // shrink width then height in the middle of a frame
  task automatic test_size_change();
    write_reg(REG_IMAGE_WIDTH, 11'd8);
    write_reg(REG_IMAGE_HEIGHT, 11'd6);
    send_random(8 * 2 + 5, 1'b1);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd4);     // column 5 is past the end: row closes
    send_random(4 * 2, 1'b0);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 11'd4);    // row 5 is past the end: frame wraps
    send_random(4 * 4, 1'b0);
    drain();
  endtask

  // bulk: small frames of random content, stray frame starts, occasional shrink
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned i;
    int unsigned mode;
    int unsigned base;
    int unsigned cur_width;
    bit          restart;
    bit          stream_open;
    stream_open = 1'b0;
    cur_width   = 0;
    while (random_sent < RANDOM_ITEMS) begin
      restart = !stream_open || $urandom_range(0, 4) != 0;
      w = restart ? $urandom_range(MIN_SIZE, 16) : $urandom_range(MIN_SIZE, cur_width);
      h = $urandom_range(MIN_SIZE, 8);
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
      write_reg(REG_CLAMP_CEILING,
                $urandom_range(0, 2) == 0 ? 11'd255 : CFG_W'($urandom_range(0, 255)));
      sender_idle_on = $urandom_range(0, 3) != 0;
      sink_stall_on  = $urandom_range(0, 3) != 0;
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 248);
      n    = $urandom_range(1, 2) * w * h + $urandom_range(0, 2 * w);
      for (i = 0; i < n; i++) begin
        send_pixel(pick_pixel(mode, base),
                   (restart && i == 0) || $urandom_range(0, 199) == 0);
        random_sent++;
      end
      drain();
      cur_width   = w;
      stream_open = 1'b1;
    end
  endtask

  // main sequence
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_IMAGE_WIDTH;
    cfg_data            = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_value = '0;
    pix_bus.frame_start = 1'b0;
    edge_bus.ready      = 1'b0;
    sender_idle_on      = 1'b0;
    sink_stall_on       = 1'b0;
    burst_left          = 0;
    stall_left          = 0;
    error_count         = 0;
    pixels_sent         = 0;
    edges_checked       = 0;
    frames_done         = 0;
    cycle_count         = 0;
    random_sent         = 0;
    pos_col             = 0;
    pos_row             = 0;
    reg_width           = WIDTH_RESET;
    reg_height          = HEIGHT_RESET;
    reg_ceiling         = CEILING_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_step_edges();
    test_clamp_ceiling();
    test_size_limits();
    test_size_change();
    test_random_frames();
    drain();

    $display("Sent %0d pixel words (%0d in random frames), checked %0d edge words,",
             pixels_sent, random_sent, edges_checked);
    $display("  %0d frames ended; rows from 3 to 640 wide, ceilings 0 to 255", frames_done);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sem_pkg.sv
src/sem_if.sv
src/sem_ram.sv
src/sem_isqrt.sv
src/sobel_edge_magnitude.sv
sim/sobel_edge_magnitude_tb.sv
